// ===== design/nge_pkg.sv =====
// Shared types and codes for the N-body gravity Euler step core.
// Holds the sequencer state type and the configuration register indices.
// No dependencies.
package nge_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAV_CONST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFTEN     = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ROW,
    S_ROWL,
    S_PAIR,
    S_DIFF,
    S_SQX,
    S_SQY,
    S_R2,
    S_SQS,
    S_SQW,
    S_GM,
    S_GMS,
    S_DVS,
    S_DVW,
    S_CX,
    S_CY,
    S_CYA,
    S_AWR,
    S_URD,
    S_UVX,
    S_UVY,
    S_UPX,
    S_UPY,
    S_UPE,
    S_OUT
  } nge_state_e;

endpackage

// ===== design/nbody_gravity_euler_step_core.sv =====
// Top level of the 2-D softened-gravity N-body core with semi-implicit Euler.
// Depends on nge_pkg, nge_mul, nge_sqrt and nge_div.
//
// Bodies arrive on the input channel, one beat each, and are stored in order.
// A beat with last_body_i set closes the set and starts the step; beats past
// MAX_BODIES are dropped, though a dropped closing beat still starts the step.
// Beats without last_body_i return nothing. While the step runs in_ready_o is
// low. Each body pair goes through the shared multiplier, the bit-serial
// square root and three passes of the bit-serial divider; once every
// pair is done, each body in turn is updated and then leaves on the output
// channel, in arrival order, last_out_o marking the final one; each waits in
// the output register until taken, so a stalled receiver simply holds the
// block. After the final beat the block returns to loading. Reset restores
// the register defaults and empties the body set; the body stores need no
// clearing.
module nbody_gravity_euler_step_core
  import nge_pkg::*;
#(
  parameter int unsigned MAX_BODIES = 64,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [31:0]   pos_x_i,
  input  logic signed [31:0]   pos_y_i,
  input  logic signed [31:0]   vel_x_i,
  input  logic signed [31:0]   vel_y_i,
  input  logic [31:0]          mass_i,
  input  logic                 last_body_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [31:0]   new_pos_x_o,
  output logic signed [31:0]   new_pos_y_o,
  output logic signed [31:0]   new_vel_x_o,
  output logic signed [31:0]   new_vel_y_o,
  output logic                 last_out_o
);

  localparam int unsigned AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int unsigned CW = $clog2(MAX_BODIES + 1);

  function automatic logic [31:0] sat66(input logic signed [65:0] t);
    if ((t[65:31] == '0) || (t[65:31] == '1)) begin
      return t[31:0];
    end
    return t[65] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return s[31:0];
  endfunction

  function automatic logic [31:0] sub_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} - {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return s[31:0];
  endfunction

  nge_state_e state_q, state_d;

  logic [31:0] step_time_q, grav_const_q, soften_q;
  logic [CW-1:0] cnt_q, n_q, i_q, j_q;
  logic [1:0]    dv_cnt_q;

  logic [63:0] pos_mem  [MAX_BODIES];
  logic [63:0] vel_mem  [MAX_BODIES];
  logic [31:0] mass_mem [MAX_BODIES];
  logic [63:0] acc_mem  [MAX_BODIES];
  logic [63:0] pos_rd_q, vel_rd_q, acc_rd_q;
  logic [31:0] mass_rd_q;
  logic [AW-1:0] rd_addr;

  logic [31:0] pix_q, piy_q, dx_q, dy_q, mass_q, ax_q, ay_q, s_q, k_q;
  logic [31:0] vx_q, vy_q, px_q, py_q;
  logic [63:0] r2_q;
  logic        last_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [65:0]        gm_sh;
  logic [31:0]        mul_q;
  logic [31:0]        sq_root, dv_quot;
  logic               sq_done, dv_done;
  logic               in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign mul_q = sat66(mul_p >>> FRAC_BITS);
  assign gm_sh = mul_p >> FRAC_BITS;

  nge_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  nge_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_SQS),
    .val_i   (r2_q),
    .root_o  (sq_root),
    .done_o  (sq_done)
  );

  nge_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_DVS),
    .k_i     (k_q),
    .s_i     (s_q),
    .quot_o  (dv_quot),
    .done_o  (dv_done)
  );

  always_comb begin
    rd_addr = (state_q == S_PAIR) ? j_q[AW-1:0] : i_q[AW-1:0];
    mul_a   = '0;
    mul_b   = '0;
    case (state_q)
      S_SQX: begin
        mul_a = {dx_q[31], dx_q};
        mul_b = {dx_q[31], dx_q};
      end
      S_SQY: begin
        mul_a = {dy_q[31], dy_q};
        mul_b = {dy_q[31], dy_q};
      end
      S_GM: begin
        mul_a = {1'b0, grav_const_q};
        mul_b = {1'b0, mass_q};
      end
      S_CX: begin
        mul_a = {dx_q[31], dx_q};
        mul_b = {1'b0, k_q};
      end
      S_CY: begin
        mul_a = {dy_q[31], dy_q};
        mul_b = {1'b0, k_q};
      end
      S_UVX: begin
        mul_a = {acc_rd_q[63], acc_rd_q[63:32]};
        mul_b = {1'b0, step_time_q};
      end
      S_UVY: begin
        mul_a = {acc_rd_q[31], acc_rd_q[31:0]};
        mul_b = {1'b0, step_time_q};
      end
      S_UPX: begin
        mul_a = {vx_q[31], vx_q};
        mul_b = {1'b0, step_time_q};
      end
      S_UPY: begin
        mul_a = {vy_q[31], vy_q};
        mul_b = {1'b0, step_time_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (cnt_q < CW'(MAX_BODIES))) begin
      pos_mem[cnt_q[AW-1:0]]  <= {pos_x_i, pos_y_i};
      vel_mem[cnt_q[AW-1:0]]  <= {vel_x_i, vel_y_i};
      mass_mem[cnt_q[AW-1:0]] <= mass_i;
    end
    if (state_q == S_AWR) begin
      acc_mem[i_q[AW-1:0]] <= {ax_q, ay_q};
    end
    pos_rd_q  <= pos_mem[rd_addr];
    vel_rd_q  <= vel_mem[rd_addr];
    mass_rd_q <= mass_mem[rd_addr];
    acc_rd_q  <= acc_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_time_q  <= 32'd655;
      grav_const_q <= 32'd65536;
      soften_q     <= 32'd655;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STEP_TIME:  step_time_q  <= cfg_data_i;
        CFG_GRAV_CONST: grav_const_q <= cfg_data_i;
        CFG_SOFTEN:     soften_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      n_q      <= '0;
      i_q      <= '0;
      j_q      <= '0;
      dv_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (cnt_q < CW'(MAX_BODIES)) begin
              cnt_q <= cnt_q + CW'(1);
              n_q   <= cnt_q + CW'(1);
            end else begin
              n_q <= cnt_q;
            end
            i_q <= '0;
          end
        end
        S_ROWL: j_q <= '0;
        S_PAIR: begin
          if ((j_q != n_q) && (j_q == i_q)) begin
            j_q <= j_q + CW'(1);
          end
        end
        S_GMS:  dv_cnt_q <= '0;
        S_DVW: begin
          if (dv_done) begin
            dv_cnt_q <= dv_cnt_q + 2'd1;
          end
        end
        S_CYA:  j_q <= j_q + CW'(1);
        S_AWR: begin
          if (i_q == n_q - CW'(1)) begin
            i_q <= '0;
          end else begin
            i_q <= i_q + CW'(1);
          end
        end
        S_OUT: begin
          if (out_acc) begin
            if (last_q) begin
              cnt_q <= '0;
            end else begin
              i_q <= i_q + CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_ROWL: begin
        pix_q <= pos_rd_q[63:32];
        piy_q <= pos_rd_q[31:0];
        ax_q  <= '0;
        ay_q  <= '0;
      end
      S_DIFF: begin
        dx_q   <= sub_sat(pos_rd_q[63:32], pix_q);
        dy_q   <= sub_sat(pos_rd_q[31:0], piy_q);
        mass_q <= mass_rd_q;
      end
      S_SQY:  r2_q <= mul_p[63:0] + ({32'd0, soften_q} << FRAC_BITS);
      S_R2:   r2_q <= r2_q + mul_p[63:0];
      S_SQW: begin
        if (sq_done) begin
          s_q <= sq_root;
        end
      end
      S_GMS:  k_q <= (|gm_sh[65:32]) ? 32'hFFFF_FFFF : gm_sh[31:0];
      S_DVW: begin
        if (dv_done) begin
          k_q <= dv_quot;
        end
      end
      S_CY:   ax_q <= add_sat(ax_q, mul_q);
      S_CYA:  ay_q <= add_sat(ay_q, mul_q);
      S_UVY:  vx_q <= add_sat(vel_rd_q[63:32], mul_q);
      S_UPX:  vy_q <= add_sat(vel_rd_q[31:0], mul_q);
      S_UPY:  px_q <= add_sat(pos_rd_q[63:32], mul_q);
      S_UPE: begin
        py_q   <= add_sat(pos_rd_q[31:0], mul_q);
        last_q <= (i_q == n_q - CW'(1));
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && last_body_i) begin
          state_d = S_ROW;
        end
      end
      S_ROW:  state_d = S_ROWL;
      S_ROWL: state_d = S_PAIR;
      S_PAIR: begin
        if (j_q == n_q) begin
          state_d = S_AWR;
        end else if (j_q != i_q) begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: state_d = S_SQX;
      S_SQX:  state_d = S_SQY;
      S_SQY:  state_d = S_R2;
      S_R2:   state_d = S_SQS;
      S_SQS:  state_d = S_SQW;
      S_SQW: begin
        if (sq_done) begin
          state_d = S_GM;
        end
      end
      S_GM:   state_d = S_GMS;
      S_GMS:  state_d = S_DVS;
      S_DVS:  state_d = S_DVW;
      S_DVW: begin
        if (dv_done) begin
          state_d = (dv_cnt_q == 2'd2) ? S_CX : S_DVS;
        end
      end
      S_CX:   state_d = S_CY;
      S_CY:   state_d = S_CYA;
      S_CYA:  state_d = S_PAIR;
      S_AWR:  state_d = (i_q == n_q - CW'(1)) ? S_URD : S_ROW;
      S_URD:  state_d = S_UVX;
      S_UVX:  state_d = S_UVY;
      S_UVY:  state_d = S_UPX;
      S_UPX:  state_d = S_UPY;
      S_UPY:  state_d = S_UPE;
      S_UPE:  state_d = S_OUT;
      S_OUT: begin
        if (out_acc) begin
          state_d = last_q ? S_IDLE : S_URD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign new_pos_x_o = px_q;
  assign new_pos_y_o = py_q;
  assign new_vel_x_o = vx_q;
  assign new_vel_y_o = vy_q;
  assign last_out_o  = last_q;

endmodule

// ===== design/nge_mul.sv =====
// Shared signed multiplier of the N-body core, one registered product a cycle.
// Operands are 33-bit signed so that unsigned 32-bit values fit. No dependencies.
module nge_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] p_o
);

  logic signed [65:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== design/nge_sqrt.sv =====
// Iterative integer square root of a 64-bit value, one result bit a cycle.
// Used by the N-body core for the softened distance. No dependencies.
module nge_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] val_i,
  output logic [31:0] root_o,
  output logic        done_o
);

  logic [63:0] val_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        fits;

  assign rem_sh = {rem_q, val_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'd1);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= val_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q <= {val_q[61:0], 2'b00};
      if (fits) begin
        rem_q  <= 34'(rem_sh - trial);
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[33:0];
        root_q <= {root_q[30:0], 1'b0};
      end
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

// ===== design/nge_div.sv =====
// Iterative restoring divider: (k << FRAC_BITS) / s, saturated to 32 bits.
// One quotient bit a cycle; used three times per pair by the N-body core.
module nge_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] k_i,
  input  logic [31:0] s_i,
  output logic [31:0] quot_o,
  output logic        done_o
);

  localparam int unsigned NW = 32 + FRAC_BITS;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] num_q;
  logic [31:0]   rem_q;
  logic [31:0]   s_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [32:0]   rem_sh;
  logic          fits;

  assign rem_sh = {rem_q, num_q[NW-1]};
  assign fits   = (rem_sh >= {1'b0, s_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {k_i, {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      s_q   <= s_i;
    end else if (busy_q) begin
      num_q <= {num_q[NW-2:0], fits};
      if (fits) begin
        rem_q <= 32'(rem_sh - {1'b0, s_q});
      end else begin
        rem_q <= rem_sh[31:0];
      end
    end
  end

  assign quot_o = ((s_q == '0) || (|num_q[NW-1:32])) ? 32'hFFFF_FFFF : num_q[31:0];
  assign done_o = done_q;

endmodule

// ===== test/tb_nbody_gravity_euler_step_core.sv =====
// Self-checking testbench for nbody_gravity_euler_step_core: drives body sets,
// predicts every updated body in fixed point and checks each output beat.
// Depends on nge_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_nbody_gravity_euler_step_core;
  import nge_pkg::*;

  typedef struct {
    bit [31:0] px, py, vx, vy;
    bit        last;
  } body_out_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [31:0]          cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic signed [31:0]   pos_x_i = '0, pos_y_i = '0, vel_x_i = '0, vel_y_i = '0;
  logic [31:0]          mass_i = '0;
  logic                 last_body_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [31:0]   new_pos_x_o, new_pos_y_o, new_vel_x_o, new_vel_y_o;
  logic                 last_out_o;

  nbody_gravity_euler_step_core DUT (.*);

  bit [31:0] dt_reg, g_reg, soft_reg;
  longint    body_pos [64][2];
  longint    body_vel [64][2];
  bit [31:0] body_mass [64];
  longint    body_acc [64][2];
  int        n_stored;
  body_out_t pending_bodies[$];
  int        errors;
  bit        calm;

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #(64'd300_000_000);
    $display("nbody_gravity_euler_step_core verification failed");
    $finish;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mul_q(longint a, bit [31:0] b);
    bit [63:0] mag;
    bit [63:0] p;
    mag = (a < 0) ? -a : a;
    p = mag * {32'b0, b};
    if (a >= 0) return longint'(p >> 16);
    return -longint'((p + 64'd65535) >> 16);
  endfunction

  function automatic bit [63:0] root64(bit [63:0] v);
    bit [63:0] r;
    bit [63:0] b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit [63:0] div_clip(bit [63:0] k, bit [63:0] s);
    bit [63:0] q;
    if (s == 0) return 64'hFFFF_FFFF;
    q = (k << 16) / s;
    return (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
  endfunction

  task automatic advance_bodies();
    int        i, j, c;
    longint    ax, ay, dx, dy, v, p;
    bit [63:0] r2, s, k, g;
    body_out_t o;
    for (i = 0; i < n_stored; i++) begin
      ax = 0;
      ay = 0;
      for (j = 0; j < n_stored; j++) begin
        if (j == i) continue;
        dx = sat32(body_pos[j][0] - body_pos[i][0]);
        dy = sat32(body_pos[j][1] - body_pos[i][1]);
        r2 = 64'(dx * dx) + 64'(dy * dy) + ({32'b0, soft_reg} << 16);
        s = root64(r2);
        g = {32'b0, g_reg};
        k = (g * {32'b0, body_mass[j]}) >> 16;
        if (k > 64'hFFFF_FFFF) k = 64'hFFFF_FFFF;
        k = div_clip(div_clip(div_clip(k, s), s), s);
        ax = sat32(ax + sat32(mul_q(dx, k[31:0])));
        ay = sat32(ay + sat32(mul_q(dy, k[31:0])));
      end
      body_acc[i][0] = ax;
      body_acc[i][1] = ay;
    end
    for (i = 0; i < n_stored; i++) begin
      for (c = 0; c < 2; c++) begin
        v = sat32(body_vel[i][c] + sat32(mul_q(body_acc[i][c], dt_reg)));
        p = sat32(body_pos[i][c] + sat32(mul_q(v, dt_reg)));
        body_vel[i][c] = v;
        body_pos[i][c] = p;
      end
      o.px = body_pos[i][0][31:0];
      o.py = body_pos[i][1][31:0];
      o.vx = body_vel[i][0][31:0];
      o.vy = body_vel[i][1][31:0];
      o.last = (i + 1 == n_stored);
      pending_bodies = {pending_bodies, o};
    end
    n_stored = 0;
  endtask

  task automatic send_body(bit [31:0] px, bit [31:0] py, bit [31:0] vx, bit [31:0] vy,
                           bit [31:0] m, bit last);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pos_x_i     <= px;
    pos_y_i     <= py;
    vel_x_i     <= vx;
    vel_y_i     <= vy;
    mass_i      <= m;
    last_body_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    if (n_stored < 64) begin
      body_pos[n_stored][0] = longint'(signed'(px));
      body_pos[n_stored][1] = longint'(signed'(py));
      body_vel[n_stored][0] = longint'(signed'(vx));
      body_vel[n_stored][1] = longint'(signed'(vy));
      body_mass[n_stored]   = m;
      n_stored++;
    end
    if (last) advance_bodies();
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_bodies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes all registers in turn, plus the unused index, which is ignored.
  task automatic write_regs(bit [31:0] dt, bit [31:0] g, bit [31:0] soften_val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_STEP_TIME;
    cfg_data_i <= dt;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_GRAV_CONST;
    cfg_data_i <= g;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SOFTEN;
    cfg_data_i <= soften_val;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_IDX_W'(3);
    cfg_data_i <= $urandom;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    dt_reg   = dt;
    g_reg    = g;
    soft_reg = soften_val;
  endtask

  function automatic bit [31:0] pick_word();
    if ($urandom_range(3) == 0) return $urandom;
    return 32'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
  endfunction

  task automatic random_set(int n);
    int k;
    for (k = 0; k < n; k++)
      send_body(pick_word(), pick_word(), pick_word(), pick_word(),
                ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0004_0000),
                k == n - 1);
  endtask

  task automatic test_drift();
    send_body(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
    send_body(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    drain();
  endtask

  task automatic test_coincident();
    write_regs(32'h0000_1000, 32'h0001_0000, 32'h0);
    send_body(32'h0002_0000, 32'h0003_0000, 32'h0, 32'h0, 32'h0001_0000, 1'b0);
    send_body(32'h0002_0000, 32'h0003_0000, 32'h0, 32'h0, 32'h0001_0000, 1'b0);
    send_body(32'h0004_0000, 32'h0003_0000, 32'h0, 32'h0, 32'h0001_0000, 1'b1);
    drain();
  endtask

  task automatic test_extremes();
    write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_body(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_body(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
    drain();
    write_regs(32'h0, 32'h0, 32'h0);
    send_body(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0);
    send_body(32'h7FFF_FFFF, 32'h1, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 1'b1);
    drain();
    write_regs(32'h0001_0000, 32'h0000_0001, 32'h0000_0001);
    send_body(32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 1'b0);
    send_body(32'h1, 32'h1, 32'h0, 32'h0, 32'h1, 1'b1);
    drain();
  endtask

  task automatic test_overflow();
    write_regs(32'd655, 32'd65536, 32'd655);
    random_set(66);
    drain();
  endtask

  task automatic test_random();
    int sets, left, n;
    sets = 0;
    left = 320;
    while (left > 0) begin
      calm = (sets >= 20 && sets < 35);
      if (sets % 6 == 5) begin
        case ($urandom_range(3))
          0: write_regs($urandom, $urandom, $urandom);
          1: write_regs($urandom_range(32'h2000), $urandom_range(32'h0004_0000),
                        $urandom_range(32'h1_0000));
          2: write_regs(32'hFFFF_FFFF, $urandom_range(32'h1_0000), 32'h0);
          default: write_regs(32'd655, 32'd65536, 32'd655);
        endcase
      end
      n = $urandom_range(1, 6);
      random_set(n);
      drain();
      left -= n;
      sets++;
    end
    calm = 1'b0;
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 19);
  end

  always @(posedge clk_i) begin
    body_out_t e;
    if (out_valid_o && out_ready_i) begin
      if (pending_bodies.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected output beat at %0t", $realtime);
      end else begin
        e = pending_bodies.pop_front();
        if (e.px !== new_pos_x_o || e.py !== new_pos_y_o || e.vx !== new_vel_x_o ||
            e.vy !== new_vel_y_o || e.last !== last_out_o) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch: expected %h %h %h %h %b, got %h %h %h %h %b",
                     e.px, e.py, e.vx, e.vy, e.last, new_pos_x_o, new_pos_y_o,
                     new_vel_x_o, new_vel_y_o, last_out_o);
        end
      end
    end
  end

  initial begin
    dt_reg   = 32'd655;
    g_reg    = 32'd65536;
    soft_reg = 32'd655;
    n_stored = 0;
    errors   = 0;
    calm     = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_drift();
    test_coincident();
    test_extremes();
    test_overflow();
    test_random();
    drain();
    if (errors == 0) begin
      $display("nbody_gravity_euler_step_core verification clean");
    end else begin
      $display("nbody_gravity_euler_step_core verification failed");
    end
    $finish;
  end

endmodule
